// ----- rtl/fpc_pkg.sv -----
`timescale 1ns / 1ps

package fpc_pkg;

  localparam int UserW     = 10;
  localparam int FeatIdxW  = 4;
  localparam int ValW      = 16;
  localparam int QW        = 15;
  localparam int OneQ14    = 16384;
  localparam int RhsShift  = 30;
  localparam int DsqW      = 2 * QW;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } fpc_op_e;

  typedef struct packed {
    logic                     opcode;
    logic [UserW-1:0]         user_a;
    logic [UserW-1:0]         user_b;
    logic [FeatIdxW-1:0]      feature_index;
    logic signed [ValW-1:0]   feature_value;
  } fpc_in_t;

  typedef struct packed {
    logic signed [ValW-1:0]   correlation;
    logic                     degenerate;
  } fpc_out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED,
    ST_WR,
    ST_BASE,
    ST_RA,
    ST_RB,
    ST_CY,
    ST_P0,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_Q0,
    ST_Q1,
    ST_Q2,
    ST_Q3,
    ST_CHK,
    ST_MC,
    ST_MP,
    ST_BS,
    ST_MB,
    ST_OUT
  } fpc_state_e;

  typedef struct packed {
    logic load_in;
    logic red_step;
    logic wr;
    logic base;
    logic rd_a;
    logic rd_b;
    logic cap_x;
    logic cap_y;
    logic p0;
    logic p1;
    logic p2;
    logic p3;
    logic q0;
    logic q1;
    logic q2;
    logic q3;
    logic mul_cov;
    logic mul_vv;
    logic mul_run;
    logic take_c;
    logic take_p;
    logic bs_load;
    logic bs_cmp;
    logic out_load;
  } fpc_cmd_t;

  typedef struct packed {
    logic is_query;
    logic red_last;
    logic feat_last;
    logic degen;
    logic mul_zero;
    logic bs_more;
    logic out_free;
  } fpc_status_t;

endpackage

// ----- rtl/feature_pearson_correlation_core.sv -----
`timescale 1ns / 1ps

// Per-user feature store with Pearson correlation queries. A write transaction
// runs a user index reduction, then one store write, and gives no result. A
// query reads both vectors through the single store read port, one feature
// pair at a time, forms the moments on one 16x16 multiplier, then runs a
// bit-serial shift-add multiplier: once for cov^2, once for var_x*var_y, and
// once per step of a 15-step binary search on the Q1.14 result.
// A zero-variance query finishes early with the degenerate flag set. One
// transaction is in flight at a time; the finished result sits in an output
// register while the next transaction is accepted.

module feature_pearson_correlation_core import fpc_pkg::*; #(
  parameter int USER_COUNT   = 1024,
  parameter int NUM_FEATURES = 10,
  parameter int FEATURE_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  fpc_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output fpc_out_t out_data_o
);

  fpc_cmd_t    cmd;
  fpc_status_t status;

  fpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fpc_datapath #(
    .USER_COUNT   (USER_COUNT),
    .NUM_FEATURES (NUM_FEATURES),
    .FEATURE_BITS (FEATURE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/fpc_ctrl.sv -----
`timescale 1ns / 1ps

module fpc_ctrl import fpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  fpc_status_t status_i,
  output fpc_cmd_t    cmd_o
);

  fpc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = ST_RED;
        end
      end
      ST_RED: begin
        cmd_o.red_step = 1'b1;
        if (status_i.red_last) begin
          state_d = status_i.is_query ? ST_BASE : ST_WR;
        end
      end
      ST_WR: begin
        cmd_o.wr = 1'b1;
        state_d = ST_IDLE;
      end
      ST_BASE: begin
        cmd_o.base = 1'b1;
        state_d = ST_RA;
      end
      ST_RA: begin
        cmd_o.rd_a = 1'b1;
        state_d = ST_RB;
      end
      ST_RB: begin
        cmd_o.rd_b  = 1'b1;
        cmd_o.cap_x = 1'b1;
        state_d = ST_CY;
      end
      ST_CY: begin
        cmd_o.cap_y = 1'b1;
        state_d = ST_P0;
      end
      ST_P0: begin
        cmd_o.p0 = 1'b1;
        state_d = ST_P1;
      end
      ST_P1: begin
        cmd_o.p1 = 1'b1;
        state_d = ST_P2;
      end
      ST_P2: begin
        cmd_o.p2 = 1'b1;
        state_d = ST_P3;
      end
      ST_P3: begin
        cmd_o.p3 = 1'b1;
        state_d = status_i.feat_last ? ST_Q0 : ST_RA;
      end
      ST_Q0: begin
        cmd_o.q0 = 1'b1;
        state_d = ST_Q1;
      end
      ST_Q1: begin
        cmd_o.q1 = 1'b1;
        state_d = ST_Q2;
      end
      ST_Q2: begin
        cmd_o.q2 = 1'b1;
        state_d = ST_Q3;
      end
      ST_Q3: begin
        cmd_o.q3 = 1'b1;
        state_d = ST_CHK;
      end
      ST_CHK: begin
        if (status_i.degen) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.mul_cov = 1'b1;
          state_d = ST_MC;
        end
      end
      ST_MC: begin
        if (status_i.mul_zero) begin
          cmd_o.take_c = 1'b1;
          cmd_o.mul_vv = 1'b1;
          state_d = ST_MP;
        end else begin
          cmd_o.mul_run = 1'b1;
        end
      end
      ST_MP: begin
        if (status_i.mul_zero) begin
          cmd_o.take_p = 1'b1;
          state_d = ST_BS;
        end else begin
          cmd_o.mul_run = 1'b1;
        end
      end
      ST_BS: begin
        if (status_i.bs_more) begin
          cmd_o.bs_load = 1'b1;
          state_d = ST_MB;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_MB: begin
        if (status_i.mul_zero) begin
          cmd_o.bs_cmp = 1'b1;
          state_d = ST_BS;
        end else begin
          cmd_o.mul_run = 1'b1;
        end
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/fpc_datapath.sv -----
`timescale 1ns / 1ps

module fpc_datapath import fpc_pkg::*; #(
  parameter int USER_COUNT   = 1024,
  parameter int NUM_FEATURES = 10,
  parameter int FEATURE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  fpc_in_t     in_data_i,
  input  fpc_cmd_t    cmd_i,
  output fpc_status_t status_o,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output fpc_out_t    out_data_o
);

  localparam int VW    = (FEATURE_BITS < ValW) ? FEATURE_BITS : ValW;
  localparam int LG    = $clog2(NUM_FEATURES + 1);
  localparam int SW    = VW + LG;
  localparam int PW    = 2 * VW + LG;
  localparam int VVW   = 2 * VW + 2 * LG + 1;
  localparam int MW    = VVW - 1;
  localparam int BW    = 2 * MW + RhsShift;
  localparam int BBW   = (MW > DsqW) ? MW : DsqW;
  localparam int DEPTH = USER_COUNT * NUM_FEATURES;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = $clog2(NUM_FEATURES);
  localparam int RW    = 32;
  localparam int KW    = $clog2(UserW);
  localparam logic signed [VVW-1:0] NfS = VVW'(NUM_FEATURES);

  logic [VW-1:0] mem [DEPTH];

  logic                  op_q;
  logic [UserW-1:0]      ua_q, ub_q;
  logic [FeatIdxW-1:0]   fi_q;
  logic [VW-1:0]         fv_q;
  logic [KW-1:0]         k_q;
  logic [AW-1:0]         base_a_q, base_b_q;
  logic [FW-1:0]         f_q;
  logic [VW-1:0]         rdata_q;
  logic signed [VW-1:0]  x_q, y_q;
  logic signed [2*VW-1:0] prod_q;
  logic signed [SW-1:0]  sx_q, sy_q;
  logic signed [PW-1:0]  sxx_q, syy_q, sxy_q;
  logic signed [2*SW-1:0] prod2_q;
  logic signed [VVW-1:0] vx_q, vy_q, cov_q;
  logic [BW-1:0]         ma_q, acc_q, rhs_q;
  logic [BBW-1:0]        mb_q;
  logic [2*MW-1:0]       pvv_q;
  logic [QW-1:0]         lo_q, hi_q, mid_q;
  fpc_out_t              out_q;
  logic                  out_valid_q;

  logic [RW-1:0]   sub;
  logic            ge_a, ge_b;
  logic [AW-1:0]   waddr, raddr;
  logic            fi_ok;
  logic [VVW-1:0]  cov_abs;
  logic            degen;
  logic [QW:0]     mid_sum;
  logic [QW-1:0]   mid;
  logic [QW:0]     dval;
  logic [DsqW-1:0] dsq;

  assign sub     = RW'(USER_COUNT) << k_q;
  assign ge_a    = RW'(ua_q) >= sub;
  assign ge_b    = RW'(ub_q) >= sub;
  assign waddr   = AW'(AW'(ua_q) * AW'(NUM_FEATURES)) + AW'(fi_q);
  assign raddr   = cmd_i.rd_a ? (base_a_q + AW'(f_q)) : (base_b_q + AW'(f_q));
  assign fi_ok   = int'(fi_q) < NUM_FEATURES;
  assign cov_abs = cov_q[VVW-1] ? VVW'(-cov_q) : VVW'(cov_q);
  assign degen   = vx_q[VVW-1] || (vx_q == '0) || vy_q[VVW-1] || (vy_q == '0);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} + (QW+1)'(1);
  assign mid     = mid_sum[QW:1];
  assign dval    = {mid, 1'b0} - (QW+1)'(1);
  assign dsq     = dval[QW-1:0] * dval[QW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr && fi_ok) begin
      mem[waddr] <= fv_q;
    end
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q <= in_data_i.opcode;
      ua_q <= in_data_i.user_a;
      ub_q <= in_data_i.user_b;
      fi_q <= in_data_i.feature_index;
      fv_q <= in_data_i.feature_value[VW-1:0];
      k_q  <= KW'(UserW - 1);
    end
    if (cmd_i.red_step) begin
      if (ge_a) ua_q <= ua_q - sub[UserW-1:0];
      if (ge_b) ub_q <= ub_q - sub[UserW-1:0];
      k_q <= k_q - KW'(1);
    end
    if (cmd_i.base) begin
      base_a_q <= AW'(AW'(ua_q) * AW'(NUM_FEATURES));
      base_b_q <= AW'(AW'(ub_q) * AW'(NUM_FEATURES));
      f_q      <= '0;
      sx_q     <= '0;
      sy_q     <= '0;
      sxx_q    <= '0;
      syy_q    <= '0;
      sxy_q    <= '0;
    end
    if (cmd_i.cap_x) x_q <= signed'(rdata_q);
    if (cmd_i.cap_y) y_q <= signed'(rdata_q);
    if (cmd_i.p0) begin
      prod_q <= x_q * x_q;
      sx_q   <= sx_q + SW'(x_q);
      sy_q   <= sy_q + SW'(y_q);
    end
    if (cmd_i.p1) begin
      sxx_q  <= sxx_q + PW'(prod_q);
      prod_q <= y_q * y_q;
    end
    if (cmd_i.p2) begin
      syy_q  <= syy_q + PW'(prod_q);
      prod_q <= x_q * y_q;
    end
    if (cmd_i.p3) begin
      sxy_q <= sxy_q + PW'(prod_q);
      f_q   <= f_q + FW'(1);
    end
    if (cmd_i.q0) prod2_q <= sx_q * sx_q;
    if (cmd_i.q1) begin
      vx_q    <= VVW'(sxx_q) * NfS - VVW'(prod2_q);
      prod2_q <= sy_q * sy_q;
    end
    if (cmd_i.q2) begin
      vy_q    <= VVW'(syy_q) * NfS - VVW'(prod2_q);
      prod2_q <= sx_q * sy_q;
    end
    if (cmd_i.q3) cov_q <= VVW'(sxy_q) * NfS - VVW'(prod2_q);
    if (cmd_i.mul_cov) begin
      ma_q  <= BW'(cov_abs[MW-1:0]);
      mb_q  <= BBW'(cov_abs[MW-1:0]);
      acc_q <= '0;
    end
    if (cmd_i.take_c) rhs_q <= acc_q << RhsShift;
    if (cmd_i.mul_vv) begin
      ma_q  <= BW'(vx_q[MW-1:0]);
      mb_q  <= BBW'(vy_q[MW-1:0]);
      acc_q <= '0;
    end
    if (cmd_i.take_p) pvv_q <= acc_q[2*MW-1:0];
    if (cmd_i.bs_load) begin
      ma_q  <= BW'(pvv_q);
      mb_q  <= BBW'(dsq);
      mid_q <= mid;
      acc_q <= '0;
    end
    if (cmd_i.mul_run) begin
      if (mb_q[0]) acc_q <= acc_q + ma_q;
      ma_q <= ma_q << 1;
      mb_q <= mb_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q        <= '0;
      hi_q        <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take_p) begin
        lo_q <= '0;
        hi_q <= QW'(OneQ14);
      end
      if (cmd_i.bs_cmp) begin
        if (acc_q <= rhs_q) lo_q <= mid_q;
        else hi_q <= mid_q - QW'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q      <= 1'b1;
        out_q.degenerate <= degen;
        if (degen) begin
          out_q.correlation <= '0;
        end else if (cov_q[VVW-1]) begin
          out_q.correlation <= signed'(-{1'b0, lo_q});
        end else begin
          out_q.correlation <= signed'({1'b0, lo_q});
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.is_query  = (op_q == OP_QUERY);
  assign status_o.red_last  = (k_q == '0);
  assign status_o.feat_last = (f_q == FW'(NUM_FEATURES - 1));
  assign status_o.degen     = degen;
  assign status_o.mul_zero  = (mb_q == '0);
  assign status_o.bs_more   = (lo_q < hi_q);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.degenerate |-> out_q.correlation == '0)
    else $error("degenerate result with nonzero correlation");

  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_q <= hi_q)
    else $error("search bounds crossed");

  a_search_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hi_q <= QW'(OneQ14))
    else $error("search bound above one");

  a_corr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.correlation <= 16'sd16384 && out_q.correlation >= -16'sd16384)
    else $error("correlation out of range");

endmodule

// ----- tb/sv/feature_pearson_correlation_core_tb.sv -----
`timescale 1ns / 1ps

module feature_pearson_correlation_core_tb import fpc_pkg::*;;

  localparam int NFeat     = 10;
  localparam int NUsers    = 1024;
  localparam int MaxCycles = 3000000;

  class corr_scoreboard;
    logic signed [ValW-1:0] store[NUsers][NFeat];
    bit                     written[NUsers][NFeat];
    fpc_out_t               expected_q[$];
    int                     errors;

    function bit ready(int u);
      for (int f = 0; f < NFeat; f++) begin
        if (!written[u][f]) return 0;
      end
      return 1;
    endfunction

    function fpc_out_t predict_corr(int ua, int ub);
      longint sx, sy, sxx, syy, sxy, vx, vy, cov, x, y;
      logic [63:0]  cmag, d;
      logic [159:0] rhs, lhs;
      int           lo, hi, mid;
      fpc_out_t     r;
      sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
      for (int f = 0; f < NFeat; f++) begin
        x = store[ua][f];
        y = store[ub][f];
        sx += x; sy += y; sxx += x * x; syy += y * y; sxy += x * y;
      end
      vx  = NFeat * sxx - sx * sx;
      vy  = NFeat * syy - sy * sy;
      cov = NFeat * sxy - sx * sy;
      r.correlation = '0;
      r.degenerate  = 1'b0;
      if (vx <= 0 || vy <= 0) begin
        r.degenerate = 1'b1;
        return r;
      end
      cmag = (cov < 0) ? -cov : cov;
      rhs  = (160'(cmag) * 160'(cmag)) << RhsShift;
      lo = 0;
      hi = OneQ14;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        d   = 64'(2 * mid - 1);
        lhs = 160'(d) * 160'(d) * 160'(vx) * 160'(vy);
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      r.correlation = ValW'((cov < 0) ? -lo : lo);
      return r;
    endfunction

    function void note_input(fpc_in_t t);
      if (t.opcode == OP_WRITE) begin
        if (t.feature_index < NFeat) begin
          store[t.user_a][t.feature_index]   = t.feature_value;
          written[t.user_a][t.feature_index] = 1;
        end
      end else begin
        expected_q.insert(expected_q.size(), predict_corr(t.user_a, t.user_b));
      end
    endfunction

    function void check_result(fpc_out_t got);
      fpc_out_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result corr=%0d degen=%0b", $time,
                 got.correlation, got.degenerate);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.correlation !== e.correlation) begin
        $display("%0t: correlation expected %0d actual %0d", $time,
                 e.correlation, got.correlation);
        errors++;
      end
      if (got.degenerate !== e.degenerate) begin
        $display("%0t: degenerate expected %0b actual %0b", $time,
                 e.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

  logic     clk_i = 0;
  logic     rst_ni = 0;
  logic     in_valid_i = 0;
  logic     in_stall_o;
  fpc_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 0;
  fpc_out_t out_data_o;

  corr_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  sent = 0;
  longint cycles = 0;
  int  user_pool[24];

  always #4 clk_i = ~clk_i;

  feature_pearson_correlation_core i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("Regression FAIL");
      $finish;
    end
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_input(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic send(fpc_in_t t);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i  <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  task automatic write_feat(int u, int f, logic [ValW-1:0] v);
    fpc_in_t t;
    t.opcode        = OP_WRITE;
    t.user_a        = UserW'(u);
    t.user_b        = UserW'($urandom);
    t.feature_index = FeatIdxW'(f);
    t.feature_value = v;
    send(t);
  endtask

  task automatic query(int a, int b);
    fpc_in_t t;
    t.opcode        = OP_QUERY;
    t.user_a        = UserW'(a);
    t.user_b        = UserW'(b);
    t.feature_index = FeatIdxW'($urandom);
    t.feature_value = ValW'($urandom);
    send(t);
  endtask

  // mode: 0 random, 1 constant, 2 affine of src, 3 negated src, 4 tiny values
  task automatic fill_user(int u, int mode, int src);
    logic signed [ValW-1:0] c, v;
    int k;
    c = ValW'($urandom);
    k = $urandom_range(3, 1);
    if (!sb.ready(src) && (mode == 2 || mode == 3)) mode = 0;
    for (int f = 0; f < NFeat; f++) begin
      case (mode)
        0: v = ValW'($urandom);
        1: v = c;
        2: v = ValW'((sb.store[src][f] >>> k) + (c >>> 2) + $signed($urandom_range(2)) - 1);
        3: v = -sb.store[src][f];
        default: v = ValW'($signed($urandom_range(16)) - 8);
      endcase
      write_feat(u, f, v);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(int items);
    int stop, r, a, b, u;
    stop = sent + items;
    while (sent < stop) begin
      r = $urandom_range(9);
      if (r < 3) begin
        u = user_pool[$urandom_range(23)];
        a = user_pool[$urandom_range(23)];
        fill_user(u, $urandom_range(4), sb.ready(a) ? a : u);
      end else if (r < 8) begin
        a = user_pool[$urandom_range(23)];
        b = (r == 7) ? a : user_pool[$urandom_range(23)];
        if (sb.ready(a) && sb.ready(b)) query(a, b);
        else fill_user(a, 0, a);
      end else begin
        write_feat($urandom_range(NUsers - 1), $urandom_range(15), ValW'($urandom));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    for (int f = 0; f < NFeat; f++) write_feat(0, f, f[0] ? 16'h8000 : 16'h7fff);
    for (int f = 0; f < NFeat; f++) write_feat(1023, f, 16'(f * 3000 - 15000));
    fill_user(1, 1, 0);
    fill_user(2, 3, 1023);
    fill_user(3, 0, 0);
    write_feat(3, 12, 16'h1234);
    write_feat(3, 15, 16'h8000);
    query(0, 1023);
    query(1023, 1023);
    query(1, 0);
    query(0, 1);
    query(1023, 2);
    query(3, 0);
    query(0, 0);

    user_pool[0] = 0; user_pool[1] = 1023; user_pool[2] = 1;
    user_pool[3] = 2; user_pool[4] = 3;
    for (int i = 5; i < 24; i++) user_pool[i] = $urandom_range(NUsers - 1);

    random_phase(100);
    send_idle_pct = 73;
    random_phase(100);
    send_idle_pct = 0;
    stall_pct = 73;
    random_phase(50);
    in_valid_i <= 0;
    wait_drained();
    random_phase(50);
    send_idle_pct = 20;
    stall_pct = 20;
    random_phase(100);
    in_valid_i <= 0;

    wait_drained();
    repeat (1000) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
